/* rtl/hdl_pkg.sv */
// Shared constants and types for the hex dump line loader.
package hdl_pkg;

    localparam int FIELD_LIMIT = 5;
    localparam int FIELD_W = $clog2(FIELD_LIMIT + 1);

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_JUMP  = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_G_UPPER = 8'h47;
    localparam logic [7:0] CH_O_LOWER = 8'h6F;

    localparam logic [63:0] WORD_BYTES = 64'd4;

    typedef enum logic [1:0] {
        GRP_NONE,
        GRP_STORE,
        GRP_GO
    } grp_code_t;

    typedef struct packed {
        grp_code_t   code;
        logic [63:0] addr;
        logic [31:0] word;
    } grp_t;

endpackage

/* rtl/hex_dump_line_loader.sv */
// Top level of the hex dump line loader: input register, parser and result sequencer.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    rx_byte
//  out      output     out_valid / out_ready  kind, reply_char, target_address, store_word, last
//
// A character is registered on acceptance and parsed from that input register.
// A character with no result frees its slot at once, so one is taken every cycle.
// The single output sequencer sets the pace otherwise: a store group has two items, a jump five.
// A group's first item is offered after the input register and the sequencer's group register.
// Reset returns the parser to line start with zero address and accumulator; a stalled
// output keeps its item, and one more character waits in the input register meanwhile.
module hex_dump_line_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  reply_char,
    output logic [63:0] target_address,
    output logic [31:0] store_word,
    output logic        last
);
    import hdl_pkg::*;

    logic       full_reg, full_next;
    logic [7:0] char_reg, char_next;
    logic       consume;
    logic       push;
    logic       can_push;
    grp_t       grp;

    assign consume  = full_reg && (grp.code == GRP_NONE || can_push);
    assign push     = consume && grp.code != GRP_NONE;
    assign in_ready = !full_reg || consume;

    always_comb
    begin
        full_next = full_reg;
        char_next = char_reg;
        if (in_valid && in_ready) begin
            full_next = 1'b1;
            char_next = rx_byte;
        end else if (consume) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    hdl_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (consume),
        .rx_char (char_reg),
        .grp     (grp)
    );

    hdl_emitter u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .grp_in         (grp),
        .can_push       (can_push),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .reply_char     (reply_char),
        .target_address (target_address),
        .store_word     (store_word),
        .last           (last)
    );

endmodule

/* rtl/hdl_parser.sv */
// Line parser: parse state and the result group that each character causes.
module hdl_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  rx_char,
    output hdl_pkg::grp_t grp
);
    import hdl_pkg::*;

    typedef enum logic [1:0] {
        MODE_LINE,
        MODE_SKIP,
        MODE_FIRST,
        MODE_DIGITS
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [FIELD_W-1:0]   field_reg, field_next;
    logic [63:0]          acc_reg, acc_next;
    logic [63:0]          load_reg, load_next;

    logic [4:0]           digit;
    logic [FIELD_W-1:0]   field_inc;
    mode_t                end_mode;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 8'd10;
            return {1'b1, v[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    assign digit     = hex_digit(rx_char);
    assign field_inc = field_reg + FIELD_W'(1);
    assign end_mode  = (rx_char == CH_NEWLINE) ? MODE_LINE : MODE_SKIP;

    always_comb
    begin
        mode_next  = mode_reg;
        field_next = field_reg;
        acc_next   = acc_reg;
        load_next  = load_reg;
        grp.code   = GRP_NONE;
        grp.addr   = load_reg;
        grp.word   = acc_reg[31:0];
        unique case (mode_reg)
            MODE_LINE:
            begin
                if (rx_char == CH_SPACE) begin
                    field_next = '0;
                    mode_next  = MODE_FIRST;
                end else begin
                    mode_next = end_mode;
                end
            end
            MODE_SKIP:
            begin
                if (rx_char == CH_NEWLINE) begin
                    mode_next = MODE_LINE;
                end
            end
            MODE_FIRST:
            begin
                if (digit[4]) begin
                    acc_next  = {60'd0, digit[3:0]};
                    mode_next = MODE_DIGITS;
                end else begin
                    mode_next = end_mode;
                end
            end
            MODE_DIGITS:
            begin
                if (digit[4]) begin
                    acc_next = {acc_reg[59:0], digit[3:0]};
                end else if (field_reg == '0 && rx_char == CH_G_UPPER) begin
                    load_next = acc_reg;
                    grp.code  = GRP_GO;
                    grp.addr  = acc_reg;
                    mode_next = MODE_LINE;
                end else begin
                    if (field_reg == '0) begin
                        load_next = acc_reg;
                    end else begin
                        grp.code  = GRP_STORE;
                        load_next = load_reg + WORD_BYTES;
                    end
                    if (rx_char == CH_SPACE) begin
                        field_next = field_inc;
                        mode_next  = (field_inc >= FIELD_W'(FIELD_LIMIT)) ? MODE_SKIP
                                                                           : MODE_FIRST;
                    end else begin
                        mode_next = end_mode;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_LINE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_LINE;
            field_reg <= '0;
            acc_reg   <= 64'd0;
            load_reg  <= 64'd0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            field_reg <= field_next;
            acc_reg   <= acc_next;
            load_reg  <= load_next;
        end
    end

endmodule

/* rtl/hdl_emitter.sv */
// Result sequencer: holds one result group and sends its items one per cycle while out_ready is high.
module hdl_emitter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hdl_pkg::grp_t grp_in,
    output logic          can_push,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    kind,
    output logic [7:0]    reply_char,
    output logic [63:0]   target_address,
    output logic [31:0]   store_word,
    output logic          last
);
    import hdl_pkg::*;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STORE_LAST = STEP_W'(1);
    localparam logic [STEP_W-1:0] GO_LAST    = STEP_W'(4);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    grp_t              grp_reg, grp_next;

    always_comb
    begin
        kind           = KIND_REPLY;
        reply_char     = 8'd0;
        target_address = 64'd0;
        store_word     = 32'd0;
        last           = 1'b0;
        if (busy_reg) begin
            unique case (grp_reg.code)
                GRP_STORE:
                begin
                    if (step_reg == '0) begin
                        kind           = KIND_STORE;
                        target_address = grp_reg.addr;
                        store_word     = grp_reg.word;
                    end else begin
                        reply_char = CH_BANG;
                        last       = 1'b1;
                    end
                end
                GRP_GO:
                begin
                    if (step_reg == GO_LAST) begin
                        kind           = KIND_JUMP;
                        target_address = grp_reg.addr;
                        last           = 1'b1;
                    end else begin
                        case (step_reg)
                            STEP_W'(0): reply_char = CH_G_UPPER;
                            STEP_W'(1): reply_char = CH_O_LOWER;
                            STEP_W'(2): reply_char = CH_RETURN;
                            default:    reply_char = CH_NEWLINE;
                        endcase
                    end
                end
                default:
                begin
                    last = 1'b1;
                end
            endcase
        end
    end

    assign out_valid = busy_reg;
    assign can_push  = !busy_reg || (out_ready && last);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        grp_next  = grp_reg;
        if (push) begin
            busy_next = 1'b1;
            step_next = '0;
            grp_next  = grp_in;
        end else if (busy_reg && out_ready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    a_store_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && grp_reg.code == GRP_STORE |-> step_reg <= STORE_LAST)
        else $error("store group step out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !busy_reg || (out_ready && last))
        else $error("result group overwritten before it was sent");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && step_reg == $past(step_reg) + 1'b1)
        else $error("sequencer did not advance to the next item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_reg))
        else $error("sequencer moved while the output was stalled");

endmodule
